/* design/scpu_pkg.sv */
// Shared constants, types and reciprocal tables of the sine/cosine polynomial unit.
// No dependencies; every other file of the unit uses this package by scoped names.
package scpu_pkg;

  localparam int LANES       = 4;
  localparam int TERMS       = 12;
  localparam int MAX_FACTORS = 11;
  // Number of nested Horner steps, one cell each.
  localparam int NF  = (TERMS - 1 > MAX_FACTORS) ? MAX_FACTORS : TERMS - 1;
  localparam int K_W = $clog2(MAX_FACTORS);

  localparam int ANG_W     = 16;
  localparam int OUT_W     = 16;
  localparam int ANGLE_MAX = 25736;
  localparam int OUT_MAX   = 16384;

  localparam int FRAC    = 28;
  localparam int ONE_Q   = 1 << FRAC;
  localparam int RECIP_W = 28;
  localparam int X2_W    = 32;
  localparam int U_W     = 31;
  localparam int T_W     = 32;
  localparam int UX_W    = X2_W + RECIP_W;
  localparam int UT_W    = U_W + 1 + T_W;
  localparam int P_W     = ANG_W + T_W;

  // Sine result is x[Q13] * t[Q28] rounded down to Q14; cosine is brought to the
  // same scale by a left shift so that one rounding stage serves both.
  localparam int OUT_SHIFT    = FRAC + 13 - 14;
  localparam int COS_PRESHIFT = OUT_SHIFT - (FRAC - 14);

  localparam logic OP_SINE   = 1'b0;
  localparam logic OP_COSINE = 1'b1;

  // Reciprocals of the factor pairs, Q0.28, rounded to nearest.
  localparam logic [RECIP_W-1:0] SIN_RECIP [MAX_FACTORS] = '{
    RECIP_W'((ONE_Q + 3) / 6),     RECIP_W'((ONE_Q + 10) / 20),
    RECIP_W'((ONE_Q + 21) / 42),   RECIP_W'((ONE_Q + 36) / 72),
    RECIP_W'((ONE_Q + 55) / 110),  RECIP_W'((ONE_Q + 78) / 156),
    RECIP_W'((ONE_Q + 105) / 210), RECIP_W'((ONE_Q + 136) / 272),
    RECIP_W'((ONE_Q + 171) / 342), RECIP_W'((ONE_Q + 210) / 420),
    RECIP_W'((ONE_Q + 253) / 506)
  };

  localparam logic [RECIP_W-1:0] COS_RECIP [MAX_FACTORS] = '{
    RECIP_W'((ONE_Q + 1) / 2),     RECIP_W'((ONE_Q + 6) / 12),
    RECIP_W'((ONE_Q + 15) / 30),   RECIP_W'((ONE_Q + 28) / 56),
    RECIP_W'((ONE_Q + 45) / 90),   RECIP_W'((ONE_Q + 66) / 132),
    RECIP_W'((ONE_Q + 91) / 182),  RECIP_W'((ONE_Q + 120) / 240),
    RECIP_W'((ONE_Q + 153) / 306), RECIP_W'((ONE_Q + 190) / 380),
    RECIP_W'((ONE_Q + 231) / 462)
  };

  typedef logic [LANES-1:0][ANG_W-1:0] ang_vec_t;
  typedef logic [LANES-1:0][OUT_W-1:0] out_vec_t;

  // Per-item data that travels down the row of cells.
  typedef struct packed {
    logic                           op;
    logic [LANES-1:0][ANG_W-1:0]    x;
    logic [LANES-1:0][X2_W-1:0]     x2;
    logic [LANES-1:0][T_W-1:0]      t;
  } lane_bus_t;

  function automatic logic [RECIP_W-1:0] recip(input logic op, input logic [K_W-1:0] k);
    logic [RECIP_W-1:0] r;
    r = '0;
    if (k < K_W'(MAX_FACTORS)) begin
      r = (op == OP_COSINE) ? COS_RECIP[k] : SIN_RECIP[k];
    end
    return r;
  endfunction

endpackage

/* design/scpu_front.sv */
// Entry stage: clamps each lane's angle to plus or minus pi and forms x squared in Q4.28.
// Depends on scpu_pkg.
module scpu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  scpu_pkg::ang_vec_t   in_x,
  output logic                 out_valid,
  input  logic                 out_ready,
  output scpu_pkg::lane_bus_t  out_bus
);

  logic                valid_r, valid_nxt;
  scpu_pkg::lane_bus_t bus_r, bus_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_bus   = bus_r;

  always_comb begin
    logic signed [scpu_pkg::ANG_W-1:0]   c;
    logic signed [2*scpu_pkg::ANG_W-1:0] sq;
    valid_nxt = valid_r;
    bus_nxt   = bus_r;
    c         = '0;
    sq        = '0;
    if (in_ready) begin
      valid_nxt  = in_valid;
      bus_nxt.op = in_op;
      for (int i = 0; i < scpu_pkg::LANES; i++) begin
        c = $signed(in_x[i]);
        if (c > scpu_pkg::ANGLE_MAX) begin
          c = scpu_pkg::ANG_W'(scpu_pkg::ANGLE_MAX);
        end else if (c < -scpu_pkg::ANGLE_MAX) begin
          c = scpu_pkg::ANG_W'(-scpu_pkg::ANGLE_MAX);
        end
        sq            = c * c;
        bus_nxt.x[i]  = c;
        bus_nxt.x2[i] = scpu_pkg::X2_W'(sq) << 2;
        bus_nxt.t[i]  = scpu_pkg::T_W'(scpu_pkg::ONE_Q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    bus_r <= bus_nxt;
  end

endmodule

/* design/scpu_cell.sv */
// One Horner step of the series: u = x^2 / d(k), then t = 1 - u * t, over two stages.
// Depends on scpu_pkg.
module scpu_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [scpu_pkg::K_W-1:0]  k,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  scpu_pkg::lane_bus_t       in_bus,
  output logic                      out_valid,
  input  logic                      out_ready,
  output scpu_pkg::lane_bus_t       out_bus
);

  localparam logic [scpu_pkg::UX_W-1:0] HALF_U = scpu_pkg::UX_W'(1) << (scpu_pkg::FRAC - 1);
  localparam logic [scpu_pkg::UT_W-1:0] HALF_T = scpu_pkg::UT_W'(1) << (scpu_pkg::FRAC - 1);

  logic                                              a_valid_r, a_valid_nxt;
  scpu_pkg::lane_bus_t                               a_bus_r, a_bus_nxt;
  logic [scpu_pkg::LANES-1:0][scpu_pkg::U_W-1:0]     a_u_r, a_u_nxt;
  logic                                              b_valid_r, b_valid_nxt;
  scpu_pkg::lane_bus_t                               b_bus_r, b_bus_nxt;
  logic                                              a_ready, b_ready;

  assign b_ready   = !b_valid_r || out_ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign in_ready  = a_ready;
  assign out_valid = b_valid_r;
  assign out_bus   = b_bus_r;

  // Stage A: scale x^2 by the reciprocal of this step's factor pair.
  always_comb begin
    logic [scpu_pkg::UX_W-1:0] prod_u;
    logic [scpu_pkg::UX_W-1:0] rnd_u;
    a_valid_nxt = a_valid_r;
    a_bus_nxt   = a_bus_r;
    a_u_nxt     = a_u_r;
    prod_u      = '0;
    rnd_u       = '0;
    if (a_ready) begin
      a_valid_nxt = in_valid;
      a_bus_nxt   = in_bus;
      for (int i = 0; i < scpu_pkg::LANES; i++) begin
        prod_u     = in_bus.x2[i] * scpu_pkg::recip(in_bus.op, k);
        rnd_u      = prod_u + HALF_U;
        a_u_nxt[i] = scpu_pkg::U_W'(rnd_u >> scpu_pkg::FRAC);
      end
    end
  end

  // Stage B: nested term. Rounding is to nearest with ties away from zero,
  // done as one add with a bias one smaller for negative products.
  always_comb begin
    logic signed [scpu_pkg::UT_W-1:0] prod_t;
    logic        [scpu_pkg::UT_W-1:0] bias;
    logic signed [scpu_pkg::UT_W-1:0] s;
    logic signed [scpu_pkg::UT_W-1:0] tn;
    b_valid_nxt = b_valid_r;
    b_bus_nxt   = b_bus_r;
    prod_t      = '0;
    bias        = '0;
    s           = '0;
    tn          = '0;
    if (b_ready) begin
      b_valid_nxt = a_valid_r;
      b_bus_nxt   = a_bus_r;
      for (int i = 0; i < scpu_pkg::LANES; i++) begin
        prod_t          = $signed({1'b0, a_u_r[i]}) * $signed(a_bus_r.t[i]);
        bias            = prod_t[scpu_pkg::UT_W-1] ? HALF_T - 1'b1 : HALF_T;
        s               = prod_t + $signed(bias);
        tn              = $signed(scpu_pkg::UT_W'(scpu_pkg::ONE_Q)) - (s >>> scpu_pkg::FRAC);
        b_bus_nxt.t[i]  = scpu_pkg::T_W'(tn);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
    a_bus_r <= a_bus_nxt;
    a_u_r   <= a_u_nxt;
    b_bus_r <= b_bus_nxt;
  end

endmodule

/* design/scpu_back.sv */
// Exit stages: final multiply by the angle for sine, rounding to Q1.14, clamp to
// plus or minus one, and the output register. Depends on scpu_pkg.
module scpu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scpu_pkg::lane_bus_t  in_bus,
  output logic                 out_valid,
  input  logic                 out_ready,
  output scpu_pkg::out_vec_t   out_value
);

  localparam logic [scpu_pkg::P_W-1:0] HALF_P =
    scpu_pkg::P_W'(1) << (scpu_pkg::OUT_SHIFT - 1);

  logic                                          p_valid_r, p_valid_nxt;
  logic [scpu_pkg::LANES-1:0][scpu_pkg::P_W-1:0] p_r, p_nxt;
  logic                                          q_valid_r, q_valid_nxt;
  scpu_pkg::out_vec_t                            q_r, q_nxt;
  logic                                          p_ready, q_ready;

  assign q_ready   = !q_valid_r || out_ready;
  assign p_ready   = !p_valid_r || q_ready;
  assign in_ready  = p_ready;
  assign out_valid = q_valid_r;
  assign out_value = q_r;

  always_comb begin
    logic signed [scpu_pkg::P_W-1:0] tx;
    p_valid_nxt = p_valid_r;
    p_nxt       = p_r;
    tx          = '0;
    if (p_ready) begin
      p_valid_nxt = in_valid;
      for (int i = 0; i < scpu_pkg::LANES; i++) begin
        tx = scpu_pkg::P_W'($signed(in_bus.t[i]));
        if (in_bus.op == scpu_pkg::OP_COSINE) begin
          p_nxt[i] = tx <<< scpu_pkg::COS_PRESHIFT;
        end else begin
          p_nxt[i] = $signed(in_bus.x[i]) * $signed(in_bus.t[i]);
        end
      end
    end
  end

  always_comb begin
    logic        [scpu_pkg::P_W-1:0] bias;
    logic signed [scpu_pkg::P_W-1:0] s;
    logic signed [scpu_pkg::P_W-1:0] r;
    q_valid_nxt = q_valid_r;
    q_nxt       = q_r;
    bias        = '0;
    s           = '0;
    r           = '0;
    if (q_ready) begin
      q_valid_nxt = p_valid_r;
      for (int i = 0; i < scpu_pkg::LANES; i++) begin
        bias = p_r[i][scpu_pkg::P_W-1] ? HALF_P - 1'b1 : HALF_P;
        s    = $signed(p_r[i]) + $signed(bias);
        r    = s >>> scpu_pkg::OUT_SHIFT;
        if (r > scpu_pkg::OUT_MAX) begin
          r = scpu_pkg::P_W'(scpu_pkg::OUT_MAX);
        end else if (r < -scpu_pkg::OUT_MAX) begin
          r = scpu_pkg::P_W'(-scpu_pkg::OUT_MAX);
        end
        q_nxt[i] = scpu_pkg::OUT_W'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      q_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
      q_valid_r <= q_valid_nxt;
    end
    p_r <= p_nxt;
    q_r <= q_nxt;
  end

endmodule

/* design/sine_cosine_polynomial_unit_top.sv */
// Four-lane sine/cosine unit: truncated Taylor series in Horner form, one cell per step.
// One entry stage, two stages in each of the NF cells, two exit stages. Throughput is
// one item per cycle while out_ready is high; every stage has its own valid bit, so
// bubbles close up under a stall. Synchronous active-low reset clears the valid bits
// only. Uses scpu_pkg, scpu_front, scpu_cell and scpu_back.
module sine_cosine_polynomial_unit_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_operation,
  input  logic signed [scpu_pkg::ANG_W-1:0]  in_angle_0,
  input  logic signed [scpu_pkg::ANG_W-1:0]  in_angle_1,
  input  logic signed [scpu_pkg::ANG_W-1:0]  in_angle_2,
  input  logic signed [scpu_pkg::ANG_W-1:0]  in_angle_3,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [scpu_pkg::OUT_W-1:0]  out_value_0,
  output logic signed [scpu_pkg::OUT_W-1:0]  out_value_1,
  output logic signed [scpu_pkg::OUT_W-1:0]  out_value_2,
  output logic signed [scpu_pkg::OUT_W-1:0]  out_value_3
);

  scpu_pkg::ang_vec_t   in_x;
  scpu_pkg::out_vec_t   values;
  logic [scpu_pkg::NF:0] chain_valid;
  logic [scpu_pkg::NF:0] chain_ready;
  scpu_pkg::lane_bus_t  chain_bus [scpu_pkg::NF+1];

  assign in_x[0] = in_angle_0;
  assign in_x[1] = in_angle_1;
  assign in_x[2] = in_angle_2;
  assign in_x[3] = in_angle_3;

  scpu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_operation),
    .in_x      (in_x),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_bus   (chain_bus[0])
  );

  // The first cell takes the innermost factor pair, the last one the outermost.
  for (genvar j = 0; j < scpu_pkg::NF; j++) begin : g_cell
    scpu_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .k         (scpu_pkg::K_W'(scpu_pkg::NF - 1 - j)),
      .in_valid  (chain_valid[j]),
      .in_ready  (chain_ready[j]),
      .in_bus    (chain_bus[j]),
      .out_valid (chain_valid[j+1]),
      .out_ready (chain_ready[j+1]),
      .out_bus   (chain_bus[j+1])
    );
  end

  scpu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[scpu_pkg::NF]),
    .in_ready  (chain_ready[scpu_pkg::NF]),
    .in_bus    (chain_bus[scpu_pkg::NF]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (values)
  );

  assign out_value_0 = values[0];
  assign out_value_1 = values[1];
  assign out_value_2 = values[2];
  assign out_value_3 = values[3];

`ifndef ASSERT_OFF
  // The only source of back-pressure is a result waiting at the output.
  a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the output is free");

  // Clamping keeps every lane within plus or minus one.
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ($signed(out_value_0) <= scpu_pkg::OUT_MAX && $signed(out_value_0) >= -scpu_pkg::OUT_MAX &&
       $signed(out_value_1) <= scpu_pkg::OUT_MAX && $signed(out_value_1) >= -scpu_pkg::OUT_MAX &&
       $signed(out_value_2) <= scpu_pkg::OUT_MAX && $signed(out_value_2) >= -scpu_pkg::OUT_MAX &&
       $signed(out_value_3) <= scpu_pkg::OUT_MAX && $signed(out_value_3) >= -scpu_pkg::OUT_MAX))
    else $error("result outside the clamped range");

  // A result appears only after an item has left the last cell, two stages earlier.
  a_output_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(chain_valid[scpu_pkg::NF], 2))
    else $error("result without an item from the cell row");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

/* verif/sine_cosine_polynomial_unit_checker.sv */
// Scoreboard for the sine/cosine polynomial unit: it watches both channels, predicts each result
// with a fixed-point Horner evaluation of its own, and counts mismatches. Depends on scpu_pkg.
`timescale 1ns / 100ps

module sine_cosine_polynomial_unit_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic                               in_operation,
  input  logic signed [scpu_pkg::ANG_W-1:0]  in_angle_0,
  input  logic signed [scpu_pkg::ANG_W-1:0]  in_angle_1,
  input  logic signed [scpu_pkg::ANG_W-1:0]  in_angle_2,
  input  logic signed [scpu_pkg::ANG_W-1:0]  in_angle_3,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [scpu_pkg::OUT_W-1:0]  out_value_0,
  input  logic signed [scpu_pkg::OUT_W-1:0]  out_value_1,
  input  logic signed [scpu_pkg::OUT_W-1:0]  out_value_2,
  input  logic signed [scpu_pkg::OUT_W-1:0]  out_value_3,
  output int                                 mismatches,
  output int                                 pending,
  output int                                 checked,
  output int                                 cosine_items
);

  localparam longint UNIT = 64'sd1 << scpu_pkg::FRAC;

  scpu_pkg::out_vec_t expected_values[$];

  // Right shift that rounds to nearest, ties away from zero.
  function automatic longint round_down(input longint v, input int s);
    longint half;
    half = 64'sd1 << (s - 1);
    if (v >= 0) begin
      return (v + half) >>> s;
    end
    return -((-v + half) >>> s);
  endfunction

  function automatic logic [scpu_pkg::OUT_W-1:0] taylor_value(input logic op,
                                                              input logic signed [15:0] angle);
    longint x, x2, t, u, d, rcp, r;
    int steps;
    x = angle;
    if (x > scpu_pkg::ANGLE_MAX) x = scpu_pkg::ANGLE_MAX;
    if (x < -scpu_pkg::ANGLE_MAX) x = -scpu_pkg::ANGLE_MAX;
    x2 = x * x * 4;
    steps = scpu_pkg::TERMS - 1;
    if (steps > scpu_pkg::MAX_FACTORS) steps = scpu_pkg::MAX_FACTORS;
    t = UNIT;
    for (int k = steps - 1; k >= 0; k--) begin
      // Cosine divides by (2k+1)(2k+2), sine by (2k+2)(2k+3).
      if (op == scpu_pkg::OP_COSINE) begin
        d = (2 * k + 1) * (2 * k + 2);
      end else begin
        d = (2 * k + 2) * (2 * k + 3);
      end
      rcp = (UNIT + d / 2) / d;
      u = round_down(x2 * rcp, scpu_pkg::FRAC);
      t = UNIT - round_down(u * t, scpu_pkg::FRAC);
    end
    if (op == scpu_pkg::OP_COSINE) begin
      r = round_down(t, scpu_pkg::FRAC - 14);
    end else begin
      r = round_down(x * t, scpu_pkg::FRAC + 13 - 14);
    end
    if (r > scpu_pkg::OUT_MAX) r = scpu_pkg::OUT_MAX;
    if (r < -scpu_pkg::OUT_MAX) r = -scpu_pkg::OUT_MAX;
    return r[scpu_pkg::OUT_W-1:0];
  endfunction

  initial begin
    mismatches   = 0;
    pending      = 0;
    checked      = 0;
    cosine_items = 0;
  end

  always @(posedge clk) begin
    scpu_pkg::ang_vec_t angles;
    scpu_pkg::out_vec_t want;
    scpu_pkg::out_vec_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        angles = {in_angle_3, in_angle_2, in_angle_1, in_angle_0};
        for (int i = 0; i < scpu_pkg::LANES; i++) begin
          want[i] = taylor_value(in_operation, angles[i]);
        end
        expected_values.push_back(want);
        if (in_operation == scpu_pkg::OP_COSINE) cosine_items++;
      end
      if (out_valid && out_ready) begin
        got = {out_value_3, out_value_2, out_value_1, out_value_0};
        if (expected_values.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result item arrived with nothing expected", $realtime);
          end
        end else begin
          want = expected_values.pop_front();
          checked++;
          for (int i = 0; i < scpu_pkg::LANES; i++) begin
            if (got[i] !== want[i]) begin
              mismatches++;
              if (mismatches <= 10) begin
                $display("%0t: value_%0d expected %0d got %0d", $realtime, i,
                         $signed(want[i]), $signed(got[i]));
              end
            end
          end
        end
      end
      pending = expected_values.size();
    end
  end

endmodule

/* verif/tb_sine_cosine_polynomial_unit_top.sv */
// Stimulus and verdict for sine_cosine_polynomial_unit_top: directed edge angles, then random
// items with random gaps and back-pressure. Depends on scpu_pkg and the checker module.
`timescale 1ns / 100ps

module tb_sine_cosine_polynomial_unit_top;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic                              in_operation;
  logic signed [scpu_pkg::ANG_W-1:0] in_angle_0;
  logic signed [scpu_pkg::ANG_W-1:0] in_angle_1;
  logic signed [scpu_pkg::ANG_W-1:0] in_angle_2;
  logic signed [scpu_pkg::ANG_W-1:0] in_angle_3;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [scpu_pkg::OUT_W-1:0] out_value_0;
  logic signed [scpu_pkg::OUT_W-1:0] out_value_1;
  logic signed [scpu_pkg::OUT_W-1:0] out_value_2;
  logic signed [scpu_pkg::OUT_W-1:0] out_value_3;

  int mismatches;
  int pending;
  int checked;
  int cosine_items;
  int items_sent;
  int wide_angles;
  int stall_left;
  bit calm;

  sine_cosine_polynomial_unit_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .in_angle_0  (in_angle_0),
    .in_angle_1  (in_angle_1),
    .in_angle_2  (in_angle_2),
    .in_angle_3  (in_angle_3),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value_0 (out_value_0),
    .out_value_1 (out_value_1),
    .out_value_2 (out_value_2),
    .out_value_3 (out_value_3)
  );

  sine_cosine_polynomial_unit_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .in_angle_0  (in_angle_0),
    .in_angle_1  (in_angle_1),
    .in_angle_2  (in_angle_2),
    .in_angle_3  (in_angle_3),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value_0 (out_value_0),
    .out_value_1 (out_value_1),
    .out_value_2 (out_value_2),
    .out_value_3 (out_value_3),
    .mismatches  (mismatches),
    .pending     (pending),
    .checked     (checked),
    .cosine_items(cosine_items)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [15:0] random_angle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return 16'($urandom_range(0, 2 * scpu_pkg::ANGLE_MAX) - scpu_pkg::ANGLE_MAX);
    if (r < 90) return 16'($urandom);
    if (r < 95) return 16'($urandom_range(0, 80) - 40);
    return 16'(($urandom_range(0, 1) ? 1 : -1) * (scpu_pkg::ANGLE_MAX - 3 + $urandom_range(0, 6)));
  endfunction

  task automatic send_item(input logic op, input logic signed [15:0] a0,
                           input logic signed [15:0] a1, input logic signed [15:0] a2,
                           input logic signed [15:0] a3);
    int gap;
    logic signed [15:0] lanes [4];
    gap = idle_length();
    lanes = '{a0, a1, a2, a3};
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_angle_0   <= a0;
    in_angle_1   <= a1;
    in_angle_2   <= a2;
    in_angle_3   <= a3;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    foreach (lanes[i]) begin
      if (lanes[i] > scpu_pkg::ANGLE_MAX || lanes[i] < -scpu_pkg::ANGLE_MAX) wide_angles++;
    end
  endtask

  // Result side: ready most of the time, with short and occasional long stalls.
  always @(negedge clk) begin
    int r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (calm || r < 75) begin
        out_ready <= 1'b1;
      end else begin
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(7, 29);
        out_ready <= 1'b0;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[sine_cosine_polynomial_unit_top] ERROR");
    $finish;
  end

  initial begin
    logic op;
    items_sent   = 0;
    wide_angles  = 0;
    stall_left   = 0;
    calm         = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = scpu_pkg::OP_SINE;
    in_angle_0   = '0;
    in_angle_1   = '0;
    in_angle_2   = '0;
    in_angle_3   = '0;
    out_ready    = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Zero, the limits of the range, quarter turns, smallest steps, and angles past pi
    // that must saturate, for both operations.
    for (int i = 0; i < 2; i++) begin
      op = (i == 0) ? scpu_pkg::OP_SINE : scpu_pkg::OP_COSINE;
      send_item(op, 16'sd0, 16'sd25736, -16'sd25736, 16'sd12868);
      send_item(op, 16'sd1, -16'sd1, 16'sd6434, -16'sd12868);
      send_item(op, 16'sd32767, -16'sd32768, 16'sd25737, -16'sd25737);
      send_item(op, 16'sd25735, -16'sd25735, 16'sd8192, -16'sd8192);
      send_item(op, 16'sd17157, -16'sd17157, 16'sd4290, -16'sd21447);
      send_item(op, -16'sd21846, 16'sh5555, 16'sd2, -16'sd2);
    end

    for (int n = 0; n < 1100; n++) begin
      // Every fourth block of a hundred items runs with no idling on either side.
      calm = ((n / 100) % 4 == 3);
      op = $urandom_range(0, 1) ? scpu_pkg::OP_COSINE : scpu_pkg::OP_SINE;
      send_item(op, random_angle(), random_angle(), random_angle(), random_angle());
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d items (%0d cosine), %0d lane angles beyond pi.", items_sent,
             cosine_items, wide_angles);
    $display("Checked %0d result items, %0d mismatching values.", checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("[sine_cosine_polynomial_unit_top] OK");
    end else begin
      $display("[sine_cosine_polynomial_unit_top] ERROR");
    end
    $finish;
  end

endmodule
